FILE: rtl/bse_pkg.sv
// Shared types, constants and helper functions of the bitmap set engine.
`default_nettype none

package bse_pkg;

  // Default bitmap capacity in bits and the matching number of bytes.
  localparam int unsigned CAPACITY_BITS_DEF = 4096;
  localparam int unsigned NUM_BYTES_DEF     = (CAPACITY_BITS_DEF + 7) / 8;

  // The search never reports a position beyond the found_position range.
  localparam int unsigned SEARCH_CAP = 4096;

  // The count result saturates at the largest value of its field.
  localparam logic [12:0] COUNT_MAX = 13'h1FFF;

  // Request codes.
  typedef enum logic [3:0] {
    KIND_SET    = 4'd0,
    KIND_CLEAR  = 4'd1,
    KIND_GET    = 4'd2,
    KIND_FLIP   = 4'd3,
    KIND_FLIPR  = 4'd4,
    KIND_AND    = 4'd5,
    KIND_OR     = 4'd6,
    KIND_XOR    = 4'd7,
    KIND_ANDNOT = 4'd8,
    KIND_COUNT  = 4'd9,
    KIND_NEXT   = 4'd10
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Number of ones in a byte.
  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bitmap_set_engine.sv
// Top level of the bitmap set engine: request decode, byte walker and result register.
// Single-bit and combine requests take one read and, except for get, one write back;
// the next request is taken only once the result is in the output register. Range flip,
// count and search stream one byte per cycle through the RAM read port. Requests that
// need no RAM access go straight to the result. A result held in the output register
// stalls the next one. After reset a clearing pass writes zero to all (CAPACITY_BITS+7)/8
// bytes, one per cycle, before the first request is accepted.
`default_nettype none

module bitmap_set_engine #(
  parameter int unsigned CAPACITY_BITS = bse_pkg::CAPACITY_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic [11:0] position_i,
  input  wire logic [12:0] range_end_i,
  input  wire logic [8:0]  byte_index_i,
  input  wire logic [7:0]  other_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             bit_value_o,
  output logic [12:0]      set_count_o,
  output logic             found_o,
  output logic [11:0]      found_position_o,
  output logic             range_error_o
);

  localparam int unsigned NUM_BYTES  = (CAPACITY_BITS + 7) / 8;
  localparam int unsigned AW         = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int unsigned SEARCH_LIM = (CAPACITY_BITS < bse_pkg::SEARCH_CAP) ?
                                       CAPACITY_BITS : bse_pkg::SEARCH_CAP;
  localparam int unsigned REM_BITS   = CAPACITY_BITS % 8;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BYTES - 1);
  localparam logic [AW-1:0] SRCH_LAST = AW'((SEARCH_LIM - 1) / 8);
  localparam logic [7:0]    LAST_MASK = (REM_BITS == 0) ? 8'hFF : 8'((1 << REM_BITS) - 1);

  bse_pkg::state_e state_q, state_d;

  // Walk control.
  logic [AW-1:0] iss_addr_q;
  logic          iss_act_q;
  logic          dv_q;
  logic [AW-1:0] daddr_q;
  logic [AW-1:0] first_q, last_q;
  logic [3:0]    kind_q;
  logic [2:0]    pos_lo_q;
  logic [2:0]    end_lo_q;
  logic [7:0]    other_q;

  // Results under construction and the output register.
  logic          res_bv_q;
  logic [12:0]   res_cnt_q;
  logic          res_found_q;
  logic [11:0]   res_fpos_q;
  logic          res_err_q;
  logic          out_valid_q;

  // Decode of the incoming request.
  logic          pos_ok, end_ok, range_nonempty, bidx_ok, srch_ok;
  logic [12:0]   end_m1;
  logic          dec_walk, dec_err;
  logic [AW-1:0] dec_first, dec_last;

  // Handshake and memory control.
  logic          in_fire, out_load, proc_done;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, rd_byte;

  // Byte processing.
  logic [7:0]    bit_mask, range_mask, srch_sel, comb_byte, new_byte;
  logic [2:0]    range_lo, range_hi, hit_idx;
  logic          hit;
  logic [13:0]   cnt_sum;

  bse_mem #(
    .DEPTH (NUM_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_byte)
  );

  // Request decode: which bytes to walk, or an immediate result.
  always_comb begin
    pos_ok         = 32'(position_i) < CAPACITY_BITS;
    end_ok         = 32'(range_end_i) <= CAPACITY_BITS;
    range_nonempty = {1'b0, position_i} < range_end_i;
    bidx_ok        = 32'(byte_index_i) < NUM_BYTES;
    srch_ok        = 32'(position_i) < SEARCH_LIM;
    end_m1         = range_end_i - 13'd1;
    dec_walk       = 1'b0;
    dec_err        = 1'b0;
    dec_first      = AW'(position_i[11:3]);
    dec_last       = AW'(position_i[11:3]);
    unique case (kind_i)
      bse_pkg::KIND_SET, bse_pkg::KIND_FLIP: begin
        dec_walk = pos_ok;
        dec_err  = !pos_ok;
      end
      bse_pkg::KIND_CLEAR, bse_pkg::KIND_GET: begin
        dec_walk = pos_ok;
      end
      bse_pkg::KIND_FLIPR: begin
        dec_err  = !end_ok;
        dec_walk = end_ok && range_nonempty;
        dec_last = AW'(end_m1[12:3]);
      end
      bse_pkg::KIND_AND, bse_pkg::KIND_OR, bse_pkg::KIND_XOR, bse_pkg::KIND_ANDNOT: begin
        dec_walk  = bidx_ok;
        dec_err   = !bidx_ok;
        dec_first = AW'(byte_index_i);
        dec_last  = AW'(byte_index_i);
      end
      bse_pkg::KIND_COUNT: begin
        dec_walk  = 1'b1;
        dec_first = '0;
        dec_last  = LAST_ADDR;
      end
      bse_pkg::KIND_NEXT: begin
        dec_walk = srch_ok;
        dec_last = SRCH_LAST;
      end
      default: begin
        dec_walk = 1'b0;
      end
    endcase
  end

  // Byte processing on the data returned by the RAM.
  always_comb begin
    bit_mask = 8'h01 << pos_lo_q;
    range_lo = (daddr_q == first_q) ? pos_lo_q : 3'd0;
    range_hi = (daddr_q == last_q) ? end_lo_q : 3'd7;
    for (int i = 0; i < 8; i++) begin
      range_mask[i] = (3'(i) >= range_lo) && (3'(i) <= range_hi);
    end
    srch_sel = rd_byte & ((daddr_q == first_q) ? (8'hFF << pos_lo_q) : 8'hFF);
    hit      = |srch_sel;
    hit_idx  = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (srch_sel[i]) begin
        hit_idx = 3'(i);
      end
    end
    cnt_sum = {1'b0, res_cnt_q} + {10'd0, bse_pkg::popcount8(rd_byte)};
    unique case (kind_q)
      bse_pkg::KIND_AND: comb_byte = rd_byte & other_q;
      bse_pkg::KIND_OR:  comb_byte = rd_byte | other_q;
      bse_pkg::KIND_XOR: comb_byte = rd_byte ^ other_q;
      default:           comb_byte = rd_byte & ~other_q;
    endcase
    unique case (kind_q)
      bse_pkg::KIND_SET:   new_byte = rd_byte | bit_mask;
      bse_pkg::KIND_CLEAR: new_byte = rd_byte & ~bit_mask;
      bse_pkg::KIND_FLIP:  new_byte = rd_byte ^ bit_mask;
      bse_pkg::KIND_FLIPR: new_byte = rd_byte ^ range_mask;
      default: new_byte = comb_byte & ((daddr_q == LAST_ADDR) ? LAST_MASK : 8'hFF);
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bse_pkg::ST_CLEAR: begin
        if (iss_addr_q == LAST_ADDR) begin
          state_d = bse_pkg::ST_IDLE;
        end
      end
      bse_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = dec_walk ? bse_pkg::ST_RUN : bse_pkg::ST_FINISH;
        end
      end
      bse_pkg::ST_RUN: begin
        if (proc_done) begin
          state_d = bse_pkg::ST_FINISH;
        end
      end
      bse_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = bse_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Handshake and memory control.
  always_comb begin
    in_ready_o = (state_q == bse_pkg::ST_IDLE);
    in_fire    = in_valid_i && in_ready_o;
    out_load   = (state_q == bse_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);
    proc_done  = (state_q == bse_pkg::ST_RUN) && dv_q &&
                 ((daddr_q == last_q) || ((kind_q == bse_pkg::KIND_NEXT) && hit));
    mem_raddr  = (state_q == bse_pkg::ST_IDLE) ? dec_first : iss_addr_q;
    mem_re     = (in_fire && dec_walk) || ((state_q == bse_pkg::ST_RUN) && iss_act_q);
    mem_we     = 1'b0;
    mem_waddr  = daddr_q;
    mem_wdata  = new_byte;
    if (state_q == bse_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = iss_addr_q;
      mem_wdata = 8'h00;
    end else if ((state_q == bse_pkg::ST_RUN) && dv_q) begin
      mem_we = (kind_q != bse_pkg::KIND_GET) && (kind_q != bse_pkg::KIND_COUNT) &&
               (kind_q != bse_pkg::KIND_NEXT);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bse_pkg::ST_CLEAR;
      iss_addr_q  <= '0;
      iss_act_q   <= 1'b0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= mem_re && (state_q != bse_pkg::ST_CLEAR);
      if (state_q == bse_pkg::ST_CLEAR) begin
        iss_addr_q <= iss_addr_q + AW'(1);
      end else if (in_fire) begin
        iss_addr_q <= dec_first + AW'(1);
        iss_act_q  <= dec_walk && (dec_first != dec_last);
      end else if (state_q == bse_pkg::ST_RUN) begin
        if (iss_act_q) begin
          iss_addr_q <= iss_addr_q + AW'(1);
        end
        iss_act_q <= iss_act_q && (iss_addr_q != last_q) && !proc_done;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request fields, walk addresses and results.
  always_ff @(posedge clk_i) begin
    daddr_q <= mem_raddr;
    if (in_fire) begin
      kind_q      <= kind_i;
      first_q     <= dec_first;
      last_q      <= dec_last;
      pos_lo_q    <= position_i[2:0];
      end_lo_q    <= end_m1[2:0];
      other_q     <= other_byte_i;
      res_bv_q    <= 1'b0;
      res_cnt_q   <= '0;
      res_found_q <= 1'b0;
      res_fpos_q  <= '0;
      res_err_q   <= dec_err;
    end else if ((state_q == bse_pkg::ST_RUN) && dv_q) begin
      unique case (kind_q)
        bse_pkg::KIND_SET, bse_pkg::KIND_CLEAR, bse_pkg::KIND_GET, bse_pkg::KIND_FLIP: begin
          res_bv_q <= rd_byte[pos_lo_q];
        end
        bse_pkg::KIND_COUNT: begin
          res_cnt_q <= (cnt_sum > {1'b0, bse_pkg::COUNT_MAX}) ? bse_pkg::COUNT_MAX :
                       cnt_sum[12:0];
        end
        bse_pkg::KIND_NEXT: begin
          if (hit) begin
            res_found_q <= 1'b1;
            res_fpos_q  <= 12'({daddr_q, hit_idx});
          end
        end
        default: begin
          res_err_q <= res_err_q;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bit_value_o      <= res_bv_q;
      set_count_o      <= res_cnt_q;
      found_o          <= res_found_q;
      found_position_o <= res_fpos_q;
      range_error_o    <= res_err_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/bse_mem.sv
// Byte-wide synchronous RAM with one write port and one registered read port.
`default_nettype none

module bse_mem #(
  parameter int unsigned DEPTH = bse_pkg::NUM_BYTES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data for an enabled read is valid in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/bitmap_set_engine_test.sv
// Self-checking testbench for the bitmap set engine with its own bitmap predictor.
`timescale 1ns / 1ps

module bitmap_set_engine_test;

  localparam int unsigned CAP       = bse_pkg::CAPACITY_BITS_DEF;
  localparam int unsigned MAP_BYTES = bse_pkg::NUM_BYTES_DEF;
  localparam int unsigned MAP_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  // Request codes that the block does not decode.
  localparam logic [3:0] KIND_SPARE_FIRST = 4'd11;
  localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;

  localparam int unsigned RANDOM_ITEMS = 1425;
  localparam int unsigned IDLE_PERCENT = 36;
  localparam int unsigned CALM_FIRST   = 700;
  localparam int unsigned CALM_LAST    = 900;
  localparam int unsigned PRESSURE_AT  = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [3:0]  kind;
    logic [11:0] position;
    logic [12:0] range_end;
    logic [8:0]  byte_index;
    logic [7:0]  other_byte;
  } request_t;

  typedef struct packed {
    logic        bit_value;
    logic [12:0] set_count;
    logic        found;
    logic [11:0] found_position;
    logic        range_error;
  } outcome_t;

  // One row of the directed table: the request and, where given, its outcome.
  typedef struct packed {
    request_t request;
    logic     given;
    outcome_t want;
  } row_t;

  localparam logic     GIVEN      = 1'b1;
  localparam logic     PREDICTED  = 1'b0;
  localparam outcome_t NO_OUTCOME = '0;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [3:0]  kind_i       = 4'd0;
  logic [11:0] position_i   = 12'd0;
  logic [12:0] range_end_i  = 13'd0;
  logic [8:0]  byte_index_i = 9'd0;
  logic [7:0]  other_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        bit_value_o;
  logic [12:0] set_count_o;
  logic        found_o;
  logic [11:0] found_position_o;
  logic        range_error_o;

  // Shadow copy of the bitmap and the outcomes still owed by the block.
  logic [7:0]  shadow_map [MAP_BYTES];
  outcome_t    pending_outcomes [$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  bitmap_set_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .range_end_i     (range_end_i),
    .byte_index_i    (byte_index_i),
    .other_byte_i    (other_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bit_value_o     (bit_value_o),
    .set_count_o     (set_count_o),
    .found_o         (found_o),
    .found_position_o(found_position_o),
    .range_error_o   (range_error_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard limit in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic request_t req(input logic [3:0] kind, input int unsigned position,
                                   input int unsigned range_end, input int unsigned byte_index,
                                   input int unsigned other_byte);
    request_t r;
    r.kind       = kind;
    r.position   = position[11:0];
    r.range_end  = range_end[12:0];
    r.byte_index = byte_index[8:0];
    r.other_byte = other_byte[7:0];
    return r;
  endfunction

  function automatic outcome_t outcome(input int unsigned bit_value, input int unsigned set_count,
                                       input int unsigned found, input int unsigned found_position,
                                       input int unsigned range_error);
    outcome_t o;
    o.bit_value      = bit_value[0];
    o.set_count      = set_count[12:0];
    o.found          = found[0];
    o.found_position = found_position[11:0];
    o.range_error    = range_error[0];
    return o;
  endfunction

  // Byte and bit of the shadow bitmap that hold a bit index.
  function automatic logic [MAP_AW-1:0] byte_of(input int unsigned p);
    return MAP_AW'(p >> 3);
  endfunction

  function automatic logic [2:0] bit_of(input int unsigned p);
    return p[2:0];
  endfunction

  // Bits beyond capacity always read as zero.
  function automatic logic bit_at(input int unsigned p);
    if (p >= CAP) begin
      return 1'b0;
    end
    return shadow_map[byte_of(p)][bit_of(p)];
  endfunction

  // Applies one request to the shadow bitmap and returns what the block must answer.
  function automatic outcome_t apply_request(input request_t r);
    outcome_t    o;
    logic [7:0]  v;
    logic [7:0]  keep;
    int unsigned p;
    int unsigned e;
    int unsigned bi;
    int unsigned b;
    int unsigned k;
    int unsigned total;
    int unsigned lim;
    o  = '0;
    p  = 32'(r.position);
    e  = 32'(r.range_end);
    bi = 32'(r.byte_index);
    case (r.kind)
      bse_pkg::KIND_SET, bse_pkg::KIND_FLIP: begin
        if (p >= CAP) begin
          o.range_error = 1'b1;
        end else begin
          o.bit_value = bit_at(p);
          if (r.kind == bse_pkg::KIND_SET) begin
            shadow_map[byte_of(p)][bit_of(p)] = 1'b1;
          end else begin
            shadow_map[byte_of(p)][bit_of(p)] = ~o.bit_value;
          end
        end
      end
      bse_pkg::KIND_CLEAR: begin
        if (p < CAP) begin
          o.bit_value = bit_at(p);
          shadow_map[byte_of(p)][bit_of(p)] = 1'b0;
        end
      end
      bse_pkg::KIND_GET: begin
        o.bit_value = bit_at(p);
      end
      bse_pkg::KIND_FLIPR: begin
        if (e > CAP) begin
          o.range_error = 1'b1;
        end else begin
          for (b = p; b < e; b++) begin
            shadow_map[byte_of(b)][bit_of(b)] = ~shadow_map[byte_of(b)][bit_of(b)];
          end
        end
      end
      bse_pkg::KIND_AND, bse_pkg::KIND_OR, bse_pkg::KIND_XOR, bse_pkg::KIND_ANDNOT: begin
        if (bi >= MAP_BYTES) begin
          o.range_error = 1'b1;
        end else begin
          v = shadow_map[MAP_AW'(bi)];
          case (r.kind)
            bse_pkg::KIND_AND: v = v & r.other_byte;
            bse_pkg::KIND_OR:  v = v | r.other_byte;
            bse_pkg::KIND_XOR: v = v ^ r.other_byte;
            default:           v = v & ~r.other_byte;
          endcase
          // Bits of the last byte that lie beyond capacity stay clear.
          if (bi * 8 + 8 <= CAP) begin
            keep = 8'hFF;
          end else if (bi * 8 >= CAP) begin
            keep = 8'h00;
          end else begin
            keep = 8'((1 << (CAP - bi * 8)) - 1);
          end
          shadow_map[MAP_AW'(bi)] = v & keep;
        end
      end
      bse_pkg::KIND_COUNT: begin
        total = 0;
        for (k = 0; k < MAP_BYTES; k++) begin
          total += 32'($countones(shadow_map[MAP_AW'(k)]));
        end
        o.set_count = (total > 32'(bse_pkg::COUNT_MAX)) ? bse_pkg::COUNT_MAX : total[12:0];
      end
      bse_pkg::KIND_NEXT: begin
        lim = (CAP < bse_pkg::SEARCH_CAP) ? CAP : bse_pkg::SEARCH_CAP;
        for (b = p; b < lim && !o.found; b++) begin
          if (bit_at(b)) begin
            o.found          = 1'b1;
            o.found_position = b[11:0];
          end
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Random request, weighted toward single-bit work, with hot spots at both ends.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned span;
    r.position   = 12'($urandom);
    r.range_end  = 13'($urandom);
    r.byte_index = 9'($urandom);
    r.other_byte = 8'($urandom);
    case ($urandom_range(3))
      0: begin
        r.position   = 12'($urandom_range(63));
        r.byte_index = 9'($urandom_range(7));
      end
      1: begin
        r.position   = 12'($urandom_range(CAP - 1, CAP - 64));
        r.byte_index = 9'($urandom_range(MAP_BYTES - 1, MAP_BYTES - 8));
      end
      default: begin
      end
    endcase
    pick = $urandom_range(99);
    if (pick < 14)      r.kind = bse_pkg::KIND_SET;
    else if (pick < 24) r.kind = bse_pkg::KIND_CLEAR;
    else if (pick < 38) r.kind = bse_pkg::KIND_GET;
    else if (pick < 48) r.kind = bse_pkg::KIND_FLIP;
    else if (pick < 56) r.kind = bse_pkg::KIND_FLIPR;
    else if (pick < 62) r.kind = bse_pkg::KIND_AND;
    else if (pick < 68) r.kind = bse_pkg::KIND_OR;
    else if (pick < 74) r.kind = bse_pkg::KIND_XOR;
    else if (pick < 80) r.kind = bse_pkg::KIND_ANDNOT;
    else if (pick < 87) r.kind = bse_pkg::KIND_COUNT;
    else if (pick < 97) r.kind = bse_pkg::KIND_NEXT;
    else r.kind = 4'($urandom_range(32'(KIND_SPARE_LAST), 32'(KIND_SPARE_FIRST)));
    // Range flips are mostly short, sometimes to the end, past capacity or empty.
    if (r.kind == bse_pkg::KIND_FLIPR) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        span        = 32'(r.position) + $urandom_range(40);
        r.range_end = 13'((span > CAP) ? CAP : span);
      end else if (pick == 7) begin
        r.range_end = 13'(CAP);
      end else if (pick == 8) begin
        r.range_end = 13'($urandom_range(8191, CAP + 1));
      end else begin
        r.range_end = 13'($urandom_range(32'(r.position)));
      end
    end
    return r;
  endfunction

  function automatic logic in_calm(input int unsigned n);
    return n >= CALM_FIRST && n < CALM_LAST;
  endfunction

  // Offers one beat, waits for it to be taken and records the outcome it owes.
  task automatic send_request(input request_t r, input logic given, input outcome_t typed_want);
    outcome_t predicted;
    while (!in_calm(items_sent) && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= r.kind;
    position_i   <= r.position;
    range_end_i  <= r.range_end;
    byte_index_i <= r.byte_index;
    other_byte_i <= r.other_byte;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predicted = apply_request(r);
    pending_outcomes.push_back(given ? typed_want : predicted);
    items_sent++;
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result side: compare each beat with the oldest owed outcome.
  initial begin : result_sink
    outcome_t    want;
    int unsigned hold_left;
    logic        pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t ns: result beat with nothing expected", $time);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("bit_value", 32'(want.bit_value), 32'(bit_value_o));
          check_field("set_count", 32'(want.set_count), 32'(set_count_o));
          check_field("found", 32'(want.found), 32'(found_o));
          check_field("found_position", 32'(want.found_position), 32'(found_position_o));
          check_field("range_error", 32'(want.range_error), 32'(range_error_o));
        end
        results_seen++;
      end
      // One long hold-off lets the block fill up and stall its input.
      if (!pressure_done && results_seen == PRESSURE_AT) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= in_calm(results_seen) || $urandom_range(99) >= IDLE_PERCENT;
      end
    end
  end

  // Request side: reset, directed table, random requests, then drain.
  initial begin : request_source
    row_t plan [$];
    foreach (shadow_map[i]) begin
      shadow_map[i] = 8'h00;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty bitmap, both ends of the bit range, whole-range flip and errors.
    plan.push_back({req(bse_pkg::KIND_COUNT, 0, 0, 0, 0), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_NEXT, 0, 0, 0, 0), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_GET, 4095, 0, 0, 0), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_SET, 0, 0, 0, 0), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_SET, 4095, 0, 0, 0), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_SET, 0, 0, 0, 0), GIVEN, outcome(1, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_NEXT, 1, 0, 0, 0), GIVEN, outcome(0, 0, 1, 4095, 0)});
    plan.push_back({req(bse_pkg::KIND_COUNT, 0, 0, 0, 0), GIVEN, outcome(0, 2, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_FLIP, 4095, 0, 0, 0), GIVEN, outcome(1, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_CLEAR, 0, 0, 0, 0), GIVEN, outcome(1, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_CLEAR, 0, 0, 0, 0), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_FLIPR, 0, 4096, 0, 0), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_COUNT, 0, 0, 0, 0), GIVEN, outcome(0, 4096, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_FLIPR, 0, 4097, 0, 0), GIVEN, outcome(0, 0, 0, 0, 1)});
    plan.push_back({req(bse_pkg::KIND_FLIPR, 4095, 8191, 511, 255), GIVEN,
                    outcome(0, 0, 0, 0, 1)});
    // Reversed range, a one-bit range at the top, search from the last bit.
    plan.push_back({req(bse_pkg::KIND_FLIPR, 100, 50, 0, 0), PREDICTED, NO_OUTCOME});
    plan.push_back({req(bse_pkg::KIND_FLIPR, 4095, 4096, 0, 0), PREDICTED, NO_OUTCOME});
    plan.push_back({req(bse_pkg::KIND_NEXT, 4095, 0, 0, 0), PREDICTED, NO_OUTCOME});
    // Byte combines at the first and last byte.
    plan.push_back({req(bse_pkg::KIND_AND, 0, 0, 511, 'h00), PREDICTED, NO_OUTCOME});
    plan.push_back({req(bse_pkg::KIND_OR, 0, 0, 0, 'hA5), PREDICTED, NO_OUTCOME});
    plan.push_back({req(bse_pkg::KIND_XOR, 0, 0, 511, 'hFF), PREDICTED, NO_OUTCOME});
    plan.push_back({req(bse_pkg::KIND_ANDNOT, 0, 0, 0, 'hFF), PREDICTED, NO_OUTCOME});
    // Undecoded kinds leave the bitmap alone and answer all zero.
    plan.push_back({req(KIND_SPARE_FIRST, 4095, 8191, 511, 255), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(KIND_SPARE_LAST, 4095, 8191, 511, 255), GIVEN, outcome(0, 0, 0, 0, 0)});
    plan.push_back({req(bse_pkg::KIND_COUNT, 0, 0, 0, 0), PREDICTED, NO_OUTCOME});

    foreach (plan[i]) begin
      send_request(plan[i].request, plan[i].given, plan[i].want);
    end
    repeat (RANDOM_ITEMS) begin
      send_request(random_request(), PREDICTED, NO_OUTCOME);
    end
    in_valid_i <= 1'b0;

    // Drain, then allow time for any stray beat to show up.
    while (pending_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
